>>> design/cmmd_pkg.sv
// Shared constants for the column min/max decimator: register indexes and
// stream word layouts. No dependencies.
`timescale 1ns / 1ps
package cmmd_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_WINDOW_START = 3'd0;
  localparam logic [2:0] REG_WINDOW_SPAN  = 3'd1;
  localparam logic [2:0] REG_PLOT_WIDTH   = 3'd2;
  localparam logic [2:0] REG_PLOT_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_PLOT_BOTTOM  = 3'd4;
  localparam logic [2:0] REG_PRICE_LOW    = 3'd5;
  localparam logic [2:0] REG_PRICE_SPAN   = 3'd6;
  localparam logic [2:0] REG_PRICE_SCALE  = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;

  localparam int IN_DATA_W  = 200;  // 194 used bits, byte padded
  localparam int OUT_DATA_W = 80;   // 73 used bits, byte padded

  localparam int TIME_W   = 34;
  localparam int PX_W     = 32;     // input price / volume field width
  localparam int VOL_W    = 40;
  localparam int Y_W      = 21;
  localparam int COL_W    = 12;

endpackage

>>> design/column_min_max_decimator.sv
// Column min/max decimator top level: sequencer, accumulators, output word.
// Depends on cmmd_pkg and cmmd_div.
`timescale 1ns / 1ps
// Bins time-sorted OHLC samples into plot columns and emits polyline vertices
// (connector, open, nearer extreme, other extreme, close) for each finished
// column. One sample is taken at a time: in_tready is high only while the
// sequencer is idle. A sample past the window start adds a multiply, a divider
// start and the divider wait before the next word can be taken. A flush walks
// its six vertex steps in order, and each vertex it emits adds the row
// multiply, magnitude, second multiply and divide, plus any time the previous
// word still waits for out_tready; a sample can emit up to ten vertices. The
// single multiplier and the single bit-serial divider are shared by the column
// lookup and the row mapping, and that divider sets the rate. A finished word
// waits in the output register while the block returns to idle and takes the
// next sample.
module column_min_max_decimator
  import cmmd_pkg::*;
#(
  parameter int MAX_COLUMNS = 4096,
  parameter int PRICE_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // time[33:0], low[65:34], high[97:66], open[129:98], close[161:130],
  // volume[193:162], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,   // final_sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // column[11:0], y_position[32:12], column_volume[72:33], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast   // last_of_run
);

  localparam int CW   = $clog2(MAX_COLUMNS);
  localparam int WW   = CW + 1;
  localparam int EW   = (WW > 13) ? WW : 13;
  localparam int MAGW = (PRICE_BITS > 32) ? PRICE_BITS : 32;
  localparam int SXW  = (PRICE_BITS > 40) ? PRICE_BITS : 40;
  localparam int CDW  = TIME_W + WW + 1;
  localparam int RDW  = MAGW + 17;
  localparam int DIVW = (CDW > RDW) ? CDW : RDW;
  localparam int MA   = (MAGW > TIME_W) ? MAGW : TIME_W;
  localparam int MB   = (WW > 24) ? WW : 24;
  localparam int MW   = MA + MB;
  localparam logic [SXW-1:0] PRICE_LIM =
    SXW'((65'(1) << PRICE_BITS) - 65'(1));
  localparam logic [22:0] QSAT = 23'(1) << 22;

  localparam logic [2:0] STEP_CONN   = 3'd0;
  localparam logic [2:0] STEP_OPEN   = 3'd1;
  localparam logic [2:0] STEP_FIRST  = 3'd2;
  localparam logic [2:0] STEP_SECOND = 3'd3;
  localparam logic [2:0] STEP_CLOSE  = 3'd4;
  localparam logic [2:0] STEP_DONE   = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_COL_MUL, S_COL_DIV, S_COL_WAIT, S_DECIDE, S_FIN, S_VTX_SEL,
    S_ROW_MUL1, S_ROW_MAG, S_ROW_MUL2, S_ROW_DIV, S_ROW_WAIT, S_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [33:0] ws_r;
  logic [23:0] wsp_r;
  logic [12:0] pw_r, ph_r;
  logic [11:0] pb_r;
  logic [31:0] pl_r, psp_r;
  logic [23:0] psc_r;

  // latched sample
  logic [TIME_W-1:0] t_r;
  logic [PX_W-1:0]   lo_r, hi_r, op_r, cl_r, vol_r;
  logic              fin_r;

  // column state
  logic [CW-1:0]   open_r, p_r, dcol_r;
  logic            has_r, inside_r, dvalid_r;
  logic [31:0]     alo_r, ahi_r, aop_r, acl_r, dclose_r;
  logic [VOL_W-1:0] avol_r;

  // vertex work
  logic [2:0]       step_r;
  logic             final_r;
  logic [31:0]      vprice_r;
  logic [COL_W-1:0] vcol_r;
  logic [VOL_W-1:0] vvol_r;
  logic             vlast_r;
  logic [MW-1:0]    mul_r;
  logic [MAGW-1:0]  mag_r;
  logic             neg_r;

  // output word
  logic             out_valid_r;
  logic [COL_W-1:0] out_col_r;
  logic [Y_W-1:0]   out_y_r;
  logic [VOL_W-1:0] out_vol_r;
  logic             out_last_r;

  // shared multiplier
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic [MW-1:0] mul_p;

  // divider
  logic            div_start, div_done;
  logic [DIVW-1:0] div_dvd, div_quo;
  logic [31:0]     div_dvs;

  logic            in_fire, out_fire;
  logic [TIME_W-1:0] in_time, d_val;
  logic [EW-1:0]   w_ext;
  logic [WW-1:0]   w_eff;
  logic [23:0]     wspan_eff;
  logic [31:0]     pspan_eff;
  logic [CW-1:0]   p_col;
  logic [VOL_W:0]  vol_sum;
  logic [VOL_W-1:0] vol_merge;

  logic            low_first, e_conn, e_first, e_second, e_close;
  logic [31:0]     first_px, second_px;
  logic [33:0]     diff_a, diff_b;
  logic            more_run;

  logic [SXW-1:0]  s_ext, s_sat;
  logic [MAGW-1:0] s_px, pl_ext;
  logic [22:0]     q_clip;
  logic signed [24:0] y_base, y_sum;
  logic [Y_W-1:0]  y_val;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_vol_r, out_y_r, out_col_r};
  assign out_tlast  = out_last_r;

  assign in_time   = in_tdata[33:0];
  assign w_ext     = (pw_r == 13'd0) ? EW'(1) :
                     ((EW'(pw_r) > EW'(MAX_COLUMNS)) ? EW'(MAX_COLUMNS) : EW'(pw_r));
  assign w_eff     = WW'(w_ext);
  assign wspan_eff = (wsp_r == 24'd0) ? 24'd1 : wsp_r;
  assign pspan_eff = (psp_r == 32'd0) ? 32'd1 : psp_r;
  assign d_val     = (t_r >= ws_r) ? (t_r - ws_r) : '0;

  // c = ceil(d*w/span); column is c-1 clamped to the last one
  assign p_col = (div_quo > DIVW'(w_eff)) ? CW'(w_eff - 1'b1) : CW'(div_quo - 1'b1);

  assign vol_sum   = {1'b0, avol_r} + (VOL_W + 1)'(vol_r);
  assign vol_merge = vol_sum[VOL_W] ? {VOL_W{1'b1}} : vol_sum[VOL_W-1:0];

  // nearer extreme first: low leads when open-low < high-open
  assign diff_a    = {2'b0, aop_r} - {2'b0, alo_r};
  assign diff_b    = {2'b0, ahi_r} - {2'b0, aop_r};
  assign low_first = $signed(diff_a) < $signed(diff_b);
  assign first_px  = low_first ? alo_r : ahi_r;
  assign second_px = low_first ? ahi_r : alo_r;
  assign e_conn    = dvalid_r && ((WW'(dcol_r) + 1'b1) != WW'(open_r));
  assign e_first   = first_px != aop_r;
  assign e_second  = second_px != first_px;
  assign e_close   = acl_r != second_px;
  // a final flush always follows a column-change flush when the sample is final
  assign more_run  = !final_r && fin_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_COL_MUL: begin
        mul_a = MA'(d_val);
        mul_b = MB'(w_eff);
      end
      S_ROW_MUL1: begin
        mul_a = MA'(vprice_r);
        mul_b = MB'(psc_r);
      end
      S_ROW_MUL2: begin
        mul_a = MA'(mag_r);
        mul_b = MB'(ph_r);
      end
      default: begin
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign div_start = (state_r == S_COL_DIV) || (state_r == S_ROW_DIV);
  assign div_dvd   = (state_r == S_COL_DIV) ?
                     (DIVW'(mul_r) + DIVW'(wspan_eff) - DIVW'(1)) :
                     (DIVW'(mul_r) << 4);
  assign div_dvs   = (state_r == S_COL_DIV) ? 32'(wspan_eff) : pspan_eff;

  // scaled price, saturated to PRICE_BITS
  assign s_ext  = SXW'(mul_r[55:16]);
  assign s_sat  = (s_ext > PRICE_LIM) ? PRICE_LIM : s_ext;
  assign s_px   = MAGW'(s_sat[PRICE_BITS-1:0]);
  assign pl_ext = MAGW'(pl_r);

  // row = bottom*16 -/+ offset, saturated to 21 bits signed
  assign q_clip = (div_quo > DIVW'(QSAT)) ? QSAT : div_quo[22:0];
  assign y_base = $signed({9'b0, pb_r, 4'b0});
  assign y_sum  = neg_r ? (y_base + $signed({2'b0, q_clip})) :
                          (y_base - $signed({2'b0, q_clip}));
  assign y_val  = (y_sum > 25'sd1048575)  ? Y_W'(21'h0FFFFF) :
                  (y_sum < -25'sd1048576) ? Y_W'(21'h100000) : y_sum[Y_W-1:0];

  cmmd_div #(.DW(DIVW), .VW(32)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ws_r        <= '0;
      wsp_r       <= 24'd3600;
      pw_r        <= 13'd640;
      ph_r        <= 13'd480;
      pb_r        <= 12'd489;
      pl_r        <= '0;
      psp_r       <= 32'd256;
      psc_r       <= 24'd65536;
      open_r      <= '0;
      has_r       <= 1'b0;
      inside_r    <= 1'b0;
      alo_r       <= '0;
      ahi_r       <= '0;
      aop_r       <= '0;
      acl_r       <= '0;
      avol_r      <= '0;
      dclose_r    <= '0;
      dcol_r      <= '0;
      dvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= STEP_CONN;
      final_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_START: ws_r  <= cfg_wdata[33:0];
          REG_WINDOW_SPAN:  wsp_r <= cfg_wdata[23:0];
          REG_PLOT_WIDTH:   pw_r  <= cfg_wdata[12:0];
          REG_PLOT_HEIGHT:  ph_r  <= cfg_wdata[12:0];
          REG_PLOT_BOTTOM:  pb_r  <= cfg_wdata[11:0];
          REG_PRICE_LOW:    pl_r  <= cfg_wdata[31:0];
          REG_PRICE_SPAN:   psp_r <= cfg_wdata[31:0];
          REG_PRICE_SCALE:  psc_r <= cfg_wdata[23:0];
          default: begin
          end
        endcase
      end

      // output register: load a new vertex or drop the accepted one
      if ((state_r == S_EMIT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            t_r   <= in_time;
            lo_r  <= in_tdata[65:34];
            hi_r  <= in_tdata[97:66];
            op_r  <= in_tdata[129:98];
            cl_r  <= in_tdata[161:130];
            vol_r <= in_tdata[193:162];
            fin_r <= in_tlast;
            if (!inside_r && (in_time < ws_r)) begin
              // lead-in before the window replaces column 0
              open_r  <= '0;
              alo_r   <= in_tdata[65:34];
              ahi_r   <= in_tdata[97:66];
              aop_r   <= in_tdata[129:98];
              acl_r   <= in_tdata[161:130];
              avol_r  <= VOL_W'(in_tdata[193:162]);
              has_r   <= 1'b1;
              state_r <= S_FIN;
            end else begin
              inside_r <= 1'b1;
              if (in_time <= ws_r) begin
                p_r     <= '0;
                state_r <= S_DECIDE;
              end else begin
                state_r <= S_COL_MUL;
              end
            end
          end
        end
        S_COL_MUL: begin
          mul_r   <= mul_p;
          state_r <= S_COL_DIV;
        end
        S_COL_DIV: begin
          state_r <= S_COL_WAIT;
        end
        S_COL_WAIT: begin
          if (div_done) begin
            p_r     <= p_col;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if ((p_r > open_r) && has_r) begin
            final_r <= 1'b0;
            step_r  <= STEP_CONN;
            state_r <= S_VTX_SEL;
          end else if ((p_r > open_r) || !has_r) begin
            if (p_r > open_r) begin
              open_r <= p_r;
            end
            alo_r   <= lo_r;
            ahi_r   <= hi_r;
            aop_r   <= op_r;
            acl_r   <= cl_r;
            avol_r  <= VOL_W'(vol_r);
            has_r   <= 1'b1;
            state_r <= S_FIN;
          end else begin
            if (lo_r < alo_r) alo_r <= lo_r;
            if (hi_r > ahi_r) ahi_r <= hi_r;
            acl_r   <= cl_r;
            avol_r  <= vol_merge;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_r) begin
            final_r <= 1'b1;
            step_r  <= STEP_CONN;
            state_r <= S_VTX_SEL;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_VTX_SEL: begin
          step_r <= (step_r == STEP_DONE) ? STEP_CONN : step_r + 1'b1;
          case (step_r)
            STEP_CONN: begin
              if (e_conn) begin
                vcol_r   <= COL_W'(open_r - 1'b1);
                vprice_r <= dclose_r;
                vvol_r   <= '0;
                vlast_r  <= 1'b0;
                state_r  <= S_ROW_MUL1;
              end
            end
            STEP_OPEN: begin
              vcol_r   <= COL_W'(open_r);
              vvol_r   <= avol_r;
              vprice_r <= aop_r;
              vlast_r  <= !(e_first || e_second || e_close) && !more_run;
              state_r  <= S_ROW_MUL1;
            end
            STEP_FIRST: begin
              if (e_first) begin
                vprice_r <= first_px;
                vlast_r  <= !(e_second || e_close) && !more_run;
                state_r  <= S_ROW_MUL1;
              end
            end
            STEP_SECOND: begin
              if (e_second) begin
                vprice_r <= second_px;
                vlast_r  <= !e_close && !more_run;
                state_r  <= S_ROW_MUL1;
              end
            end
            STEP_CLOSE: begin
              if (e_close) begin
                vprice_r <= acl_r;
                vlast_r  <= !more_run;
                state_r  <= S_ROW_MUL1;
              end
            end
            default: begin
              // flush finished
              if (final_r) begin
                open_r   <= '0;
                has_r    <= 1'b0;
                inside_r <= 1'b0;
                alo_r    <= '0;
                ahi_r    <= '0;
                aop_r    <= '0;
                acl_r    <= '0;
                avol_r   <= '0;
                dclose_r <= '0;
                dcol_r   <= '0;
                dvalid_r <= 1'b0;
                state_r  <= S_IDLE;
              end else begin
                dclose_r <= acl_r;
                dcol_r   <= open_r;
                dvalid_r <= 1'b1;
                open_r   <= p_r;
                alo_r    <= lo_r;
                ahi_r    <= hi_r;
                aop_r    <= op_r;
                acl_r    <= cl_r;
                avol_r   <= VOL_W'(vol_r);
                has_r    <= 1'b1;
                state_r  <= S_FIN;
              end
            end
          endcase
        end
        S_ROW_MUL1: begin
          mul_r   <= mul_p + MW'(32'h8000);
          state_r <= S_ROW_MAG;
        end
        S_ROW_MAG: begin
          neg_r   <= s_px < pl_ext;
          mag_r   <= (s_px < pl_ext) ? (pl_ext - s_px) : (s_px - pl_ext);
          state_r <= S_ROW_MUL2;
        end
        S_ROW_MUL2: begin
          mul_r   <= mul_p;
          state_r <= S_ROW_DIV;
        end
        S_ROW_DIV: begin
          state_r <= S_ROW_WAIT;
        end
        S_ROW_WAIT: begin
          if (div_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_col_r   <= vcol_r;
            out_y_r     <= y_val;
            out_vol_r   <= vvol_r;
            out_last_r  <= vlast_r;
            state_r     <= S_VTX_SEL;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/cmmd_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing; used by column_min_max_decimator.
`timescale 1ns / 1ps
module cmmd_div #(
  parameter int DW = 49,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo_r;
  logic [VW-1:0]    rem_r;
  logic [VW-1:0]    dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [VW:0]      trial;
  logic             fits;

  assign trial    = {rem_r, quo_r[DW-1]};
  assign fits     = trial >= {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= dividend;
        rem_r <= '0;
        dvs_r <= divisor;
        cnt_r <= CNT_W'(DW);
      end else if (cnt_r != '0) begin
        rem_r <= fits ? VW'(trial - {1'b0, dvs_r}) : trial[VW-1:0];
        quo_r <= {quo_r[DW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/cmmd_chk.sv
// Port-level checker for column_min_max_decimator, bound to the top level.
// Depends on cmmd_pkg.
`timescale 1ns / 1ps
module cmmd_chk
  import cmmd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // one sample at a time: busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("took a word while busy");

  // reset empties the output register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:73] == '0)
    else $error("nonzero padding in output word");

endmodule

bind column_min_max_decimator cmmd_chk u_cmmd_chk (.*);
